// ----- rtl/bpjq_pkg.sv -----
// Shared types and codes for the bounded priority job queue.
// No dependencies; imported by the channel interfaces, the core and its checker.
package bpjq_pkg;

  localparam int JOB_W    = 8;
  localparam int RANK_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [JOB_W-1:0]   job_id_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [COUNT_W-1:0] count_t;

  // operation carried by an input transaction
  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // one queue slot as held in the slot memory
  typedef struct packed {
    job_id_t job_id;
    rank_t   rank;
  } slot_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_EXT_HEAD,
    S_EXT_SHIFT,
    S_DONE
  } state_t;

endpackage

// ----- rtl/bpjq_if.sv -----
// Valid/ready channel interfaces for job requests and queue results.
// Depends on bpjq_pkg for the payload types.
interface bpjq_in_if import bpjq_pkg::*; ();
  logic    valid;
  logic    ready;
  func_t   func;
  job_id_t job_id;
  rank_t   rank;

  modport source (output valid, func, job_id, rank, input ready);
  modport sink   (input valid, func, job_id, rank, output ready);
endinterface

interface bpjq_out_if import bpjq_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  job_id_t out_job_id;
  rank_t   out_rank;
  count_t  count;

  modport source (output valid, status, out_job_id, out_rank, count, input ready);
  modport sink   (input valid, status, out_job_id, out_rank, count, output ready);
endinterface

// ----- rtl/bounded_priority_job_queue_core.sv -----
// Bounded priority job queue: slots sorted by rank, highest first, FIFO among equals.
// An insert scans from the tail, moving each lower-ranked slot one place back; an extract
// moves each remaining slot one place forward. Throughput: one transaction at a time, bounded
// by the single read and single write port of the slot memory moving one slot per cycle.
// Reset: sequencer idle, occupancy zero, output empty; slot memory is not cleared.
// Depends on bpjq_pkg and bpjq_if.
module bounded_priority_job_queue_core import bpjq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bpjq_in_if.sink    in_ch,
  bpjq_out_if.source out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // control registers
  state_t state_r, state_nxt;
  cnt_t   occ_r, occ_nxt;
  logic   out_valid_r, out_valid_nxt;

  // working and result registers
  idx_t    idx_r, idx_nxt;
  slot_t   new_r, new_nxt;
  status_t res_status_r, res_status_nxt;
  slot_t   res_slot_r, res_slot_nxt;
  status_t out_status_r, out_status_nxt;
  slot_t   out_slot_r, out_slot_nxt;
  count_t  out_count_r, out_count_nxt;

  // slot memory ports
  slot_t slot_mem [CAPACITY];
  slot_t rd_data_r;
  logic  rd_en, wr_en;
  idx_t  rd_addr, wr_addr;
  slot_t wr_data;

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  // sequencer: next state, memory accesses and result
  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r;
    idx_nxt        = idx_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = new_r;

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          new_nxt        = '{job_id: in_ch.job_id, rank: in_ch.rank};
          res_status_nxt = ST_DONE;
          res_slot_nxt   = '0;
          if (in_ch.func == FUNC_INSERT) begin
            if (occ_r >= cnt_t'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else if (occ_r == '0) begin
              // first job goes straight to the head
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = '{job_id: in_ch.job_id, rank: in_ch.rank};
              occ_nxt   = cnt_t'(1);
              state_nxt = S_DONE;
            end else begin
              // scan from the tail towards the head
              rd_en     = 1'b1;
              rd_addr   = idx_t'(occ_r - cnt_t'(1));
              idx_nxt   = idx_t'(occ_r - cnt_t'(1));
              state_nxt = S_INS;
            end
          end else begin
            if (occ_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_EXT_HEAD;
            end
          end
        end
      end

      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_t'(idx_r + idx_t'(1));
        if (rd_data_r.rank >= new_r.rank) begin
          // new job lands behind this one
          wr_data   = new_r;
          occ_nxt   = cnt_t'(occ_r + cnt_t'(1));
          state_nxt = S_DONE;
        end else begin
          // move this slot one place back
          wr_data = rd_data_r;
          if (idx_r == '0) begin
            state_nxt = S_INS_HEAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_t'(idx_r - idx_t'(1));
            idx_nxt = idx_t'(idx_r - idx_t'(1));
          end
        end
      end

      S_INS_HEAD: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_r;
        occ_nxt   = cnt_t'(occ_r + cnt_t'(1));
        state_nxt = S_DONE;
      end

      S_EXT_HEAD: begin
        res_slot_nxt = rd_data_r;
        if (occ_r == cnt_t'(1)) begin
          occ_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_t'(1);
          idx_nxt   = '0;
          state_nxt = S_EXT_SHIFT;
        end
      end

      S_EXT_SHIFT: begin
        // close the gap one slot at a time
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
        if ((cnt_t'(idx_r) + cnt_t'(2)) == occ_r) begin
          occ_nxt   = cnt_t'(occ_r - cnt_t'(1));
          state_nxt = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_t'(idx_r + idx_t'(2));
          idx_nxt = idx_t'(idx_r + idx_t'(1));
        end
      end

      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_count_nxt  = count_t'(occ_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.out_job_id = out_slot_r.job_id;
  assign out_ch.out_rank   = out_slot_r.rank;
  assign out_ch.count      = out_count_r;

endmodule

// ----- rtl/bpjq_checker.sv -----
// Port-level checker for the priority job queue core, and its bind.
// Depends on bpjq_pkg for the status codes.
module bpjq_checker import bpjq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input status_t out_status,
  input job_id_t out_job_id,
  input rank_t   out_rank,
  input count_t  out_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_job_id)
      && $stable(out_rank) && $stable(out_count))
    else $error("result changed while stalled");

  // failed transactions (full or empty) return no job
  a_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_job_id == '0 && out_rank == '0)
    else $error("job fields set on a failed transaction");

  // a dropped insert reports a full queue
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == count_t'(CAPACITY))
    else $error("full status with wrong count");

  // an empty extract reports zero jobs
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_count == '0)
    else $error("empty status with non-zero count");

endmodule

bind bounded_priority_job_queue_core bpjq_checker #(.CAPACITY(CAPACITY)) u_bpjq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_job_id (out_ch.out_job_id),
  .out_rank   (out_ch.out_rank),
  .out_count  (out_ch.count)
);
